### rtl/b32d_pkg.sv
// Shared types, constants and the character-to-symbol map of the base32 decoder.
package b32d_pkg;

   localparam int unsigned CharWidth    = 8;
   localparam int unsigned SymbolWidth  = 5;
   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned GroupSymbols = 8;
   localparam int unsigned StoreDepth   = GroupSymbols - 1;
   localparam int unsigned GroupBytes   = 5;
   localparam int unsigned WordWidth    = GroupBytes * ByteWidth;
   localparam int unsigned CountWidth   = $clog2(GroupSymbols);
   localparam int unsigned NbytesWidth  = $clog2(GroupBytes + 1);

   localparam logic [CountWidth-1:0]  LastSlot   = CountWidth'(StoreDepth);
   localparam logic [ByteWidth-1:0]   PadByte    = 8'h80;
   localparam logic [CharWidth-1:0]   LowerFirst = 8'd97;
   localparam logic [CharWidth-1:0]   LowerTop   = 8'd127;
   localparam logic [SymbolWidth-1:0] LowerBias  = 5'd1;   // (c - 97) mod 32
   localparam logic [SymbolWidth-1:0] OtherBias  = 5'd10;  // (c - 22) mod 32

   typedef struct packed {
      logic [CharWidth-1:0] code_char;
      logic                 final_block;
      logic                 padded;
   } req_beat_type;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 last_of_run;
   } rsp_beat_type;

   // Collector to output buffer: a finished group and how many bytes survive.
   typedef struct packed {
      logic                   complete;
      logic [WordWidth-1:0]   word;
      logic [NbytesWidth-1:0] nbytes;
   } group_type;

   function automatic logic [SymbolWidth-1:0] map_symbol(input logic [CharWidth-1:0] c);
      logic [SymbolWidth-1:0] sym;
      if (c >= LowerFirst && c <= LowerTop) begin
         sym = c[SymbolWidth-1:0] - LowerBias;
      end else begin
         sym = c[SymbolWidth-1:0] + OtherBias;
      end
      return sym;
   endfunction

endpackage

### rtl/base32_interleaved_decoder_top.sv
// Top level of the interleaved base32 decoder.
//
// Takes one encoded character per beat and returns decoded bytes. Each
// character maps to a 5-bit symbol; every eight symbols form a group whose
// symbol pairs are bit-interleaved (first symbol's bit, then second's, MSB
// first) into a 40-bit word sent out as five byte beats, the last one
// flagged last_of_run. On the eighth character, if final_block and padded
// are both set, the bytes stop before the first 0x80 byte (possibly none).
// The flags are ignored on the other seven characters. A character is held
// in the input register and consumed from there; the decoder sustains one
// character per cycle. A group's bytes leave from a result register, one per
// cycle unless rsp_stall is high, while the next group's characters keep
// arriving; the input stalls only when a group completes while the previous
// group's bytes are still waiting on rsp_stall. The eighth character is held
// in the input register, then its group in the result register that drives rsp_beat.
module base32_interleaved_decoder_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  b32d_pkg::req_beat_type req_beat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output b32d_pkg::rsp_beat_type rsp_beat
);

   logic                   held_valid;
   b32d_pkg::req_beat_type held_beat;
   b32d_pkg::group_type    group;
   logic                   free;
   logic                   advance;
   logic                   load;

   // A held character moves on unless it completes a group while the
   // result register still owes bytes of the previous one.
   assign advance = held_valid && (!group.complete || free);
   assign load    = advance && group.complete;

   b32d_input_stage u_input_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_beat   (req_beat),
      .advance    (advance),
      .held_valid (held_valid),
      .held_beat  (held_beat)
   );

   b32d_collector u_collector (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .beat  (held_beat),
      .group (group)
   );

   // A fully cut group loads a zero count and emits nothing.
   b32d_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .group     (group),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

endmodule

### rtl/b32d_input_stage.sv
// Input register of the base32 decoder: holds one request beat until it advances.
module b32d_input_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  b32d_pkg::req_beat_type req_beat,
   input  logic                 advance,
   output logic                 held_valid,
   output b32d_pkg::req_beat_type held_beat
);

   logic                   valid_ff;
   logic                   valid_in;
   b32d_pkg::req_beat_type beat_ff;

   // Stall only while a held beat cannot move on.
   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         beat_ff <= req_beat;
      end
   end

   assign held_valid = valid_ff;
   assign held_beat  = beat_ff;

endmodule

### rtl/b32d_collector.sv
// Symbol store, group packing and padding cutoff of the base32 decoder.
module b32d_collector (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  b32d_pkg::req_beat_type beat,
   output b32d_pkg::group_type    group
);

   logic [b32d_pkg::SymbolWidth-1:0] store_ff [b32d_pkg::StoreDepth];
   logic [b32d_pkg::CountWidth-1:0]  count_ff;
   logic [b32d_pkg::CountWidth-1:0]  count_in;
   logic [b32d_pkg::SymbolWidth-1:0] sym;
   logic                             complete;
   logic [b32d_pkg::WordWidth-1:0]   word;
   logic [b32d_pkg::NbytesWidth-1:0] nbytes;
   logic [b32d_pkg::SymbolWidth-1:0] first;
   logic [b32d_pkg::SymbolWidth-1:0] second;
   logic                             cut;

   assign sym      = b32d_pkg::map_symbol(beat.code_char);
   assign complete = (count_ff == b32d_pkg::LastSlot);
   assign count_in = complete ? '0 : count_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && !complete) begin
         store_ff[count_ff] <= sym;
      end
   end

   // Pairs interleave bit by bit, first symbol's bit ahead, MSB first.
   always_comb begin
      word = '0;
      for (int p = 0; p < b32d_pkg::GroupSymbols / 2; p++) begin
         first  = store_ff[2 * p];
         second = (p == b32d_pkg::GroupSymbols / 2 - 1) ? sym : store_ff[2 * p + 1];
         for (int b = 0; b < b32d_pkg::SymbolWidth; b++) begin
            word[b32d_pkg::WordWidth - 1 - (p * 2 * b32d_pkg::SymbolWidth)
                 - 2 * (b32d_pkg::SymbolWidth - 1 - b)] = first[b];
            word[b32d_pkg::WordWidth - 2 - (p * 2 * b32d_pkg::SymbolWidth)
                 - 2 * (b32d_pkg::SymbolWidth - 1 - b)] = second[b];
         end
      end
   end

   // Output ends before the first pad byte on a padded final group.
   assign cut = beat.final_block && beat.padded;

   always_comb begin
      nbytes = b32d_pkg::NbytesWidth'(b32d_pkg::GroupBytes);
      for (int j = b32d_pkg::GroupBytes - 1; j >= 0; j--) begin
         if (cut && word[b32d_pkg::WordWidth - 1 - j * b32d_pkg::ByteWidth -: b32d_pkg::ByteWidth]
                    == b32d_pkg::PadByte) begin
            nbytes = b32d_pkg::NbytesWidth'(j);
         end
      end
   end

   assign group.complete = complete;
   assign group.word     = word;
   assign group.nbytes   = nbytes;

endmodule

### rtl/b32d_out_buffer.sv
// Result register of the base32 decoder: drains one group as byte beats.
module b32d_out_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  b32d_pkg::group_type    group,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output b32d_pkg::rsp_beat_type rsp_beat
);

   logic [b32d_pkg::WordWidth-1:0]   word_ff;
   logic [b32d_pkg::WordWidth-1:0]   word_in;
   logic [b32d_pkg::NbytesWidth-1:0] left_ff;
   logic [b32d_pkg::NbytesWidth-1:0] left_in;
   logic                             take;

   assign rsp_valid = (left_ff != '0);
   assign take      = rsp_valid && !rsp_stall;
   // Free once the last byte is gone or leaves this cycle.
   assign free      = !rsp_valid || (left_ff == 1 && !rsp_stall);

   always_comb begin
      word_in = word_ff;
      left_in = left_ff;
      if (load) begin
         word_in = group.word;
         left_in = group.nbytes;
      end else if (take) begin
         word_in = word_ff << b32d_pkg::ByteWidth;
         left_in = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_beat.data_byte   = word_ff[b32d_pkg::WordWidth-1 -: b32d_pkg::ByteWidth];
   assign rsp_beat.last_of_run = (left_ff == 1);

endmodule

### dv/b32d_decode_checker.sv
`timescale 1ns / 1ps
// Checker for the base32 decoder: watches both channels, predicts decoded bytes, compares.
module b32d_decode_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  b32d_pkg::req_beat_type req_beat,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  b32d_pkg::rsp_beat_type rsp_beat,
   output int unsigned            mismatch_total,
   output int unsigned            bytes_outstanding,
   output int unsigned            groups_decoded,
   output int unsigned            groups_cut,
   output int unsigned            bytes_checked
);

   logic [4:0] held_symbols [7];
   logic [2:0] held_count;
   b32d_pkg::rsp_beat_type expected_bytes [$];

   initial begin
      mismatch_total    = 0;
      bytes_outstanding = 0;
      groups_decoded    = 0;
      groups_cut        = 0;
      bytes_checked     = 0;
      held_count        = '0;
   end

   // lowercase block 97..127 is offset by 97, everything else by 22 (mod 32)
   function automatic logic [4:0] symbol_of(input logic [7:0] c);
      logic [7:0] diff;
      if (c >= 8'd97 && c <= 8'd127) begin
         diff = c - 8'd97;
      end else begin
         diff = c - 8'd22;
      end
      return diff[4:0];
   endfunction

   // symbol i sits at syms[5*i +: 5]; pairs interleave first/second, MSB first
   function automatic logic [39:0] interleave_group(input logic [39:0] syms);
      logic [39:0] word;
      logic [4:0]  first;
      logic [4:0]  second;
      word = '0;
      for (int p = 0; p < 4; p++) begin
         first  = syms[10*p +: 5];
         second = syms[10*p+5 +: 5];
         for (int b = 4; b >= 0; b--) begin
            word = {word[37:0], first[b], second[b]};
         end
      end
      return word;
   endfunction

   task automatic take_char(input b32d_pkg::req_beat_type beat);
      logic [4:0]  sym;
      logic [39:0] syms;
      logic [39:0] word;
      logic [7:0]  one_byte;
      int          keep;
      b32d_pkg::rsp_beat_type want;
      sym = symbol_of(beat.code_char);
      if (held_count != 3'd7) begin
         held_symbols[held_count] = sym;
         held_count = held_count + 3'd1;
      end else begin
         for (int i = 0; i < 7; i++) begin
            syms[5*i +: 5] = held_symbols[i];
         end
         syms[35 +: 5] = sym;
         held_count = '0;
         word = interleave_group(syms);
         // pad cutoff only applies on a final, padded group
         keep = 5;
         for (int j = 0; j < 5; j++) begin
            one_byte = word[39-8*j -: 8];
            if (beat.final_block && beat.padded && one_byte == 8'h80 && keep == 5) begin
               keep = j;
            end
         end
         for (int j = 0; j < keep; j++) begin
            want.data_byte   = word[39-8*j -: 8];
            want.last_of_run = (j == keep - 1);
            expected_bytes.push_back(want);
         end
         groups_decoded++;
         if (keep < 5) begin
            groups_cut++;
         end
      end
   endtask

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatch_total++;
      if (mismatch_total <= 10) begin
         $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
      end
   endtask

   task automatic check_byte(input b32d_pkg::rsp_beat_type got);
      b32d_pkg::rsp_beat_type want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
         note_mismatch("unexpected beat, data_byte", 0, got.data_byte);
      end else begin
         want = expected_bytes.pop_front();
         if (got.data_byte !== want.data_byte) begin
            note_mismatch("data_byte", want.data_byte, got.data_byte);
         end
         if (got.last_of_run !== want.last_of_run) begin
            note_mismatch("last_of_run", want.last_of_run, got.last_of_run);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count = '0;
         foreach (held_symbols[i]) held_symbols[i] = '0;
         expected_bytes.delete();
      end else begin
         if (req_valid && !req_stall) take_char(req_beat);
         if (rsp_valid && !rsp_stall) check_byte(rsp_beat);
      end
      bytes_outstanding <= expected_bytes.size();
   end

endmodule

### dv/base32_interleaved_decoder_top_test.sv
`timescale 1ns / 1ps
// Test top for the base32 decoder: clock, reset, character stimulus, back-pressure, verdict.
module base32_interleaved_decoder_top_test;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   b32d_pkg::req_beat_type req_beat;
   logic                   rsp_valid;
   logic                   rsp_stall;
   b32d_pkg::rsp_beat_type rsp_beat;

   int unsigned mismatch_total;
   int unsigned bytes_outstanding;
   int unsigned groups_decoded;
   int unsigned groups_cut;
   int unsigned bytes_checked;
   int unsigned chars_sent;

   // steady: both sides stop idling; hold_wanted: receiver starts one long hold-off
   bit steady;
   bit hold_wanted;

   base32_interleaved_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   // Prediction and comparison live in the checker; this top only drives and judges.
   b32d_decode_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_beat          (req_beat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_beat          (rsp_beat),
      .mismatch_total    (mismatch_total),
      .bytes_outstanding (bytes_outstanding),
      .groups_decoded    (groups_decoded),
      .groups_cut        (groups_cut),
      .bytes_checked     (bytes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #3_000_000;
      $display("[base32_interleaved_decoder_top] ERROR");
      $finish;
   end

   // Result side: random stall about 17% of cycles, plus one long hold-off on request.
   // The hold-off is counted here so the sender keeps pushing characters meanwhile,
   // which should fill the group buffer and push back on req_stall.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (150) @(posedge clock);
         end
         rsp_stall <= !steady && ($urandom_range(0, 99) < 17);
      end
   end

   // One character beat. Called right after a rising edge; returns at the edge that
   // accepted it, so the next call can keep valid high without a bubble.
   task automatic put_char(input logic [7:0] c, input logic fb, input logic pd);
      int gap;
      if (!steady && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_beat.code_char   <= c;
      req_beat.final_block <= fb;
      req_beat.padded      <= pd;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   // Pick a random character that decodes to symbol s. Symbol 31 has no
   // lowercase form (128 falls outside the lowercase block).
   function automatic logic [7:0] char_for(input logic [4:0] s);
      logic [7:0] c;
      if (s != 5'd31 && $urandom_range(0, 1) == 1) begin
         c = 8'd97 + 8'(s);
      end else begin
         do c = {3'($urandom_range(0, 7)), 5'(s + 5'd22)}; while (c >= 8'd97 && c <= 8'd127);
      end
      return c;
   endfunction

   // Send eight characters that decode to the given 40-bit word. Flags on the
   // first seven are random noise; the block only looks at them on the eighth.
   // With raw set, characters are random bytes instead and the word is ignored.
   task automatic send_group(input logic [39:0] word, input logic fb, input logic pd,
                             input bit raw);
      logic [9:0] pair;
      logic [4:0] sym;
      logic [7:0] c;
      for (int i = 0; i < 8; i++) begin
         pair = word[39-10*(i/2) -: 10];
         sym  = (i % 2 == 0) ? {pair[9], pair[7], pair[5], pair[3], pair[1]}
                             : {pair[8], pair[6], pair[4], pair[2], pair[0]};
         c    = raw ? 8'($urandom_range(0, 255)) : char_for(sym);
         if (i == 7) begin
            put_char(c, fb, pd);
         end else begin
            put_char(c, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Sender pause: drop valid and wait for every predicted byte to come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (bytes_outstanding != 0);
   endtask

   initial begin
      logic [39:0] word;
      logic [63:0] wide;
      logic        fb;
      logic        pd;
      int          slot;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_beat    = '0;
      steady      = 1'b0;
      hold_wanted = 1'b0;
      chars_sent  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: byte extremes and both map boundaries; flags set on the early
      // characters must be ignored, eighth says final but not padded -> 5 bytes.
      put_char(8'h00, 1'b1, 1'b1);
      put_char(8'hFF, 1'b1, 1'b1);
      put_char(8'd97, 1'b1, 1'b1);
      put_char(8'd127, 1'b1, 1'b1);
      put_char(8'd96, 1'b1, 1'b1);
      put_char(8'h80, 1'b1, 1'b1);
      put_char(8'd122, 1'b1, 1'b1);
      put_char(8'd53, 1'b1, 1'b0);
      // Padded final group whose first byte is the pad byte: nothing comes out.
      send_group(40'h80_11_22_33_44, 1'b1, 1'b1, 1'b0);
      // Padded final group cut after two bytes.
      send_group(40'h12_34_80_80_56, 1'b1, 1'b1, 1'b0);
      drain();

      // Random groups. Half carry a pad byte somewhere, most eighth characters
      // are final+padded so the cutoff gets hit at every position.
      for (int g = 0; g < 47; g++) begin
         steady = (g >= 10 && g < 18);
         if (g == 25) hold_wanted = 1'b1;
         wide = {$urandom, $urandom};
         word = wide[39:0];
         if ($urandom_range(0, 1) == 1) begin
            slot = $urandom_range(0, 4);
            word[39-8*slot -: 8] = 8'h80;
         end
         if ($urandom_range(0, 9) < 6) begin
            fb = 1'b1;
            pd = 1'b1;
         end else begin
            fb = 1'($urandom_range(0, 1));
            pd = 1'($urandom_range(0, 1));
         end
         send_group(word, fb, pd, $urandom_range(0, 3) == 0);
         if (g % 12 == 11) drain();
      end
      steady = 1'b0;

      drain();
      repeat (20) @(posedge clock);

      $display("Sent %0d characters; %0d groups decoded, %0d of them cut at a pad byte.",
               chars_sent, groups_decoded, groups_cut);
      $display("Checked %0d byte beats under random stalls and one long result hold-off.",
               bytes_checked);
      if (bytes_outstanding != 0) begin
         $display("%0d predicted bytes never arrived", bytes_outstanding);
      end
      if (mismatch_total == 0 && bytes_outstanding == 0) begin
         $display("[base32_interleaved_decoder_top] OK");
      end else begin
         $display("[base32_interleaved_decoder_top] ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/b32d_pkg.sv
rtl/b32d_input_stage.sv
rtl/b32d_collector.sv
rtl/b32d_out_buffer.sv
rtl/base32_interleaved_decoder_top.sv
dv/b32d_decode_checker.sv
dv/base32_interleaved_decoder_top_test.sv
